/* sv/adtti_pkg.sv */
// Shared types, constants and the diode sensor table for the ADC to temperature converter.
// Used by every module of the block; it depends on nothing else.
package adtti_pkg;

  // Converter and table geometry.
  localparam int ADC_BITS      = 12;
  localparam int ADC_W         = 12;
  localparam int TABLE_ENTRIES = 34;

  // Field widths.
  localparam int CH_W     = 3;
  localparam int TEMP_W   = 20;
  localparam int OFFSET_W = 21;
  localparam int GAIN_W   = 16;
  localparam int CFG_W    = 21;

  // Internal widths. V_W holds the scaled code, VIN_W the diode voltage with offset.
  localparam int V_W   = 22;
  localparam int Y_W   = 24;
  localparam int VIN_W = 23;
  localparam int UV_W  = 21;
  localparam int MK_W  = 19;

  // The widest table segment spans 25228 uV and 10000 mK.
  localparam int DV_W  = 15;
  localparam int DT_W  = 14;
  localparam int NUM_W = DT_W + DV_W;
  localparam int RCP_W = 18;
  localparam int RCP_SHIFT = NUM_W;

  // Scaling by full scale over the largest code: code*FS/MAX = Q*code + (R*code)/MAX.
  localparam longint unsigned MAXCODE     = (64'd1 << ADC_BITS) - 64'd1;
  localparam longint unsigned FULL_UV     = 64'd2500000;
  localparam longint unsigned LIN_UV      = FULL_UV / 5;
  localparam int              RECIP_SHIFT = 35;

  localparam logic [V_W-1:0] Q_DIODE   = V_W'(FULL_UV / MAXCODE);
  localparam logic [V_W-1:0] Q_LIN     = V_W'(LIN_UV / MAXCODE);
  localparam logic [Y_W-1:0] R_DIODE   = Y_W'(FULL_UV % MAXCODE);
  localparam logic [Y_W-1:0] R_LIN     = Y_W'(LIN_UV % MAXCODE);
  localparam logic [Y_W-1:0] HALF_CODE = Y_W'(MAXCODE / 2);
  localparam logic [Y_W-1:0] SCALE_RECIP =
    Y_W'(((64'd1 << RECIP_SHIFT) + MAXCODE - 64'd1) / MAXCODE);

  localparam int GAIN_SHIFT = 16;
  localparam logic [V_W+GAIN_W-1:0] GAIN_ROUND = (V_W + GAIN_W)'(32768);

  localparam logic signed [TEMP_W-1:0] KELVIN_MILLI = 20'sd273150;

  // Pipeline stage positions.
  localparam int NUM_STAGES = 9;
  localparam int ST_MULT = 0;
  localparam int ST_RECIP = 1;
  localparam int ST_VIN = 2;
  localparam int ST_CMP = 3;
  localparam int ST_SEG = 4;
  localparam int ST_NUM = 5;
  localparam int ST_QEST = 6;
  localparam int ST_QCHK = 7;
  localparam int ST_OUT = 8;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_OFFSET = 1'b0,
    CFG_GAIN   = 1'b1
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [1:0] {
    CLAMP_NONE   = 2'd0,
    CLAMP_TOP    = 2'd1,
    CLAMP_BOTTOM = 2'd2
  } clamp_e;

  // Per-stage load enables.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

  // Scaled values leaving the front end.
  typedef struct packed {
    logic [VIN_W-1:0]         vin;
    logic signed [TEMP_W-1:0] lin;
    logic                     diode;
  } front_t;

  // Selected table segment leaving the search.
  typedef struct packed {
    logic [DV_W-1:0]          dv;
    logic [DV_W-1:0]          span_uv;
    logic [DT_W-1:0]          span_mk;
    logic [RCP_W-1:0]         rcp;
    logic [MK_W-1:0]          tprev;
    clamp_e                   status;
    logic signed [TEMP_W-1:0] lin;
    logic                     diode;
  } seg_t;

  // Silicon diode table, voltage rising and temperature falling.
  localparam logic [UV_W-1:0] TAB_UV [TABLE_ENTRIES] = '{
    21'd449594,  21'd474822,  21'd499958,  21'd525021,  21'd550000,  21'd574880,
    21'd599653,  21'd616583,  21'd624308,  21'd648837,  21'd673232,  21'd697486,
    21'd721587,  21'd745530,  21'd769304,  21'd792899,  21'd816302,  21'd839502,
    21'd862483,  21'd885224,  21'd907702,  21'd929885,  21'd951741,  21'd973233,
    21'd994324,  21'd1014970, 21'd1035122, 21'd1045000, 21'd1054744, 21'd1059853,
    21'd1064352, 21'd1073825, 21'd1083167, 21'd1092385
  };

  localparam logic [MK_W-1:0] TAB_MK [TABLE_ENTRIES] = '{
    19'd340000, 19'd330000, 19'd320000, 19'd310000, 19'd300000, 19'd290000,
    19'd280000, 19'd273000, 19'd270000, 19'd260000, 19'd250000, 19'd240000,
    19'd230000, 19'd220000, 19'd210000, 19'd200000, 19'd190000, 19'd180000,
    19'd170000, 19'd160000, 19'd150000, 19'd140000, 19'd130000, 19'd120000,
    19'd110000, 19'd100000, 19'd90000,  19'd85000,  19'd80000,  19'd77350,
    19'd75000,  19'd70000,  19'd65000,  19'd60000
  };

endpackage

/* sv/adtti_front.sv */
// Front end: scales the converter code to microvolts and forms the diode voltage.
// Three pipeline stages; depends on adtti_pkg.
module adtti_front (
  input  logic                             clk_i,
  input  adtti_pkg::pipe_ctl_t             ctl_i,
  input  logic [adtti_pkg::CH_W-1:0]       channel_i,
  input  logic [adtti_pkg::ADC_W-1:0]      adc_code_i,
  input  logic [adtti_pkg::OFFSET_W-1:0]   diode_offset_i,
  input  logic [adtti_pkg::GAIN_W-1:0]     diode_gain_i,
  output adtti_pkg::front_t                front_o
);

  logic [adtti_pkg::ADC_BITS-1:0] code;
  logic                           diode_a_d, diode_a_q;
  logic [adtti_pkg::V_W-1:0]      q_sel, p_d, p_q;
  logic [adtti_pkg::Y_W-1:0]      r_sel, y_d, y_q;
  logic                           diode_b_q;
  logic [2*adtti_pkg::Y_W-1:0]    yprod;
  logic [adtti_pkg::V_W-1:0]      v_d, v_q;
  logic [adtti_pkg::V_W+adtti_pkg::GAIN_W-1:0] gprod;
  adtti_pkg::front_t              front_d, front_q;

  // Split the scale into a whole part and a remainder still to be divided.
  always_comb begin
    code      = adc_code_i[adtti_pkg::ADC_BITS-1:0];
    diode_a_d = (channel_i[adtti_pkg::CH_W-1:1] == '0);
    q_sel     = diode_a_d ? adtti_pkg::Q_DIODE : adtti_pkg::Q_LIN;
    r_sel     = diode_a_d ? adtti_pkg::R_DIODE : adtti_pkg::R_LIN;
    p_d       = adtti_pkg::V_W'(code) * q_sel;
    y_d       = adtti_pkg::Y_W'(code) * r_sel + adtti_pkg::HALF_CODE;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[adtti_pkg::ST_MULT]) begin
      diode_a_q <= diode_a_d;
      p_q       <= p_d;
      y_q       <= y_d;
    end
  end

  // Divide the remainder by the largest code through its reciprocal.
  always_comb begin
    yprod = (2 * adtti_pkg::Y_W)'(y_q) * (2 * adtti_pkg::Y_W)'(adtti_pkg::SCALE_RECIP);
    v_d   = p_q + adtti_pkg::V_W'(yprod >> adtti_pkg::RECIP_SHIFT);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[adtti_pkg::ST_RECIP]) begin
      diode_b_q <= diode_a_q;
      v_q       <= v_d;
    end
  end

  // Apply gain and offset for the diode, or the kelvin offset for a linear sensor.
  always_comb begin
    gprod = (adtti_pkg::V_W + adtti_pkg::GAIN_W)'(v_q)
          * (adtti_pkg::V_W + adtti_pkg::GAIN_W)'(diode_gain_i)
          + adtti_pkg::GAIN_ROUND;
    front_d.vin   = adtti_pkg::VIN_W'(diode_offset_i)
                  + adtti_pkg::VIN_W'(gprod >> adtti_pkg::GAIN_SHIFT);
    front_d.lin   = $signed(adtti_pkg::TEMP_W'(v_q)) - adtti_pkg::KELVIN_MILLI;
    front_d.diode = diode_b_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[adtti_pkg::ST_VIN]) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

/* sv/adtti_search.sv */
// Table search: compares the diode voltage with every table entry and picks the segment.
// Two pipeline stages; depends on adtti_pkg.
module adtti_search (
  input  logic                 clk_i,
  input  adtti_pkg::pipe_ctl_t ctl_i,
  input  adtti_pkg::front_t    front_i,
  output adtti_pkg::seg_t      seg_o
);

  localparam int N = adtti_pkg::TABLE_ENTRIES;

  logic [N-1:0]                    ge_d, ge_q;
  adtti_pkg::front_t               front_q;
  logic [N-1:0]                    hit;
  logic [adtti_pkg::DV_W-1:0]      seg_dv  [N];
  logic [adtti_pkg::DT_W-1:0]      seg_dt  [N];
  logic [adtti_pkg::RCP_W-1:0]     seg_rcp [N];
  logic [adtti_pkg::UV_W-1:0]      seg_vp  [N];
  logic [adtti_pkg::MK_W-1:0]      seg_tp  [N];
  logic [adtti_pkg::UV_W-1:0]      vprev;
  adtti_pkg::seg_t                 seg_d, seg_q;

  // Constant per-segment spans and reciprocals, segment g lies between entries g-1 and g.
  for (genvar g = 0; g < N; g++) begin : g_seg
    if (g == 0) begin : g_none
      assign seg_dv[g]  = '0;
      assign seg_dt[g]  = '0;
      assign seg_rcp[g] = '0;
      assign seg_vp[g]  = '0;
      assign seg_tp[g]  = '0;
    end else begin : g_span
      localparam logic [adtti_pkg::DV_W-1:0] SPAN_UV =
        adtti_pkg::DV_W'(adtti_pkg::TAB_UV[g] - adtti_pkg::TAB_UV[g-1]);
      localparam logic [adtti_pkg::DT_W-1:0] SPAN_MK =
        adtti_pkg::DT_W'(adtti_pkg::TAB_MK[g-1] - adtti_pkg::TAB_MK[g]);
      localparam logic [adtti_pkg::RCP_W-1:0] RCP =
        adtti_pkg::RCP_W'((2 ** adtti_pkg::RCP_SHIFT)
                          / (adtti_pkg::TAB_UV[g] - adtti_pkg::TAB_UV[g-1]));
      assign seg_dv[g]  = SPAN_UV;
      assign seg_dt[g]  = SPAN_MK;
      assign seg_rcp[g] = RCP;
      assign seg_vp[g]  = adtti_pkg::TAB_UV[g-1];
      assign seg_tp[g]  = adtti_pkg::TAB_MK[g-1];
    end
  end

  // One comparator per table entry.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ge_d[i] = (adtti_pkg::VIN_W'(adtti_pkg::TAB_UV[i]) >= front_i.vin);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[adtti_pkg::ST_CMP]) begin
      ge_q    <= ge_d;
      front_q <= front_i;
    end
  end

  // The table rises, so the compare vector is a thermometer and its edge marks the segment.
  always_comb begin
    hit[0] = ge_q[0];
    for (int i = 1; i < N; i++) begin
      hit[i] = ge_q[i] & ~ge_q[i-1];
    end
    seg_d.span_uv = '0;
    seg_d.span_mk = '0;
    seg_d.rcp     = '0;
    seg_d.tprev   = '0;
    vprev         = '0;
    for (int i = 1; i < N; i++) begin
      seg_d.span_uv = seg_d.span_uv | ({adtti_pkg::DV_W{hit[i]}} & seg_dv[i]);
      seg_d.span_mk = seg_d.span_mk | ({adtti_pkg::DT_W{hit[i]}} & seg_dt[i]);
      seg_d.rcp     = seg_d.rcp | ({adtti_pkg::RCP_W{hit[i]}} & seg_rcp[i]);
      seg_d.tprev   = seg_d.tprev | ({adtti_pkg::MK_W{hit[i]}} & seg_tp[i]);
      vprev         = vprev | ({adtti_pkg::UV_W{hit[i]}} & seg_vp[i]);
    end
    seg_d.dv = adtti_pkg::DV_W'(front_q.vin - adtti_pkg::VIN_W'(vprev));

    // Clamp past the next-to-last entry first, then at or below the first entry.
    if (!front_q.diode) begin
      seg_d.status = adtti_pkg::CLAMP_NONE;
    end else if (!ge_q[N-2]) begin
      seg_d.status = adtti_pkg::CLAMP_BOTTOM;
    end else if (ge_q[0]) begin
      seg_d.status = adtti_pkg::CLAMP_TOP;
    end else begin
      seg_d.status = adtti_pkg::CLAMP_NONE;
    end
    seg_d.lin   = front_q.lin;
    seg_d.diode = front_q.diode;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[adtti_pkg::ST_SEG]) begin
      seg_q <= seg_d;
    end
  end

  assign seg_o = seg_q;

endmodule

/* sv/adtti_interp.sv */
// Interpolation inside the chosen segment and the output register.
// Four pipeline stages with a reciprocal divide and one correction step; depends on adtti_pkg.
module adtti_interp (
  input  logic                              clk_i,
  input  adtti_pkg::pipe_ctl_t              ctl_i,
  input  adtti_pkg::seg_t                   seg_i,
  output logic signed [adtti_pkg::TEMP_W-1:0] temperature_milli_o,
  output logic                              is_kelvin_o,
  output logic [1:0]                        clamp_status_o
);

  localparam int N = adtti_pkg::TABLE_ENTRIES;
  localparam int QP_W = adtti_pkg::NUM_W + adtti_pkg::RCP_W;

  adtti_pkg::seg_t                  f_q, g_q, h_q;
  logic [adtti_pkg::NUM_W-1:0]      num_d, num_f_q, num_g_q, num_h_q;
  logic [QP_W-1:0]                  qprod;
  logic [adtti_pkg::DT_W-1:0]       qe_d, qe_g_q, qe_h_q;
  logic [adtti_pkg::NUM_W-1:0]      qd_d, qd_q;
  logic [adtti_pkg::NUM_W-1:0]      rem;
  logic [adtti_pkg::DT_W-1:0]       quot;
  logic signed [adtti_pkg::TEMP_W-1:0] temp_d, temp_q;
  logic                             kelvin_q;
  adtti_pkg::clamp_e                status_q;

  // Numerator of the step, rounded half up.
  always_comb begin
    num_d = adtti_pkg::NUM_W'(seg_i.span_mk) * adtti_pkg::NUM_W'(seg_i.dv)
          + adtti_pkg::NUM_W'(seg_i.span_uv >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[adtti_pkg::ST_NUM]) begin
      f_q     <= seg_i;
      num_f_q <= num_d;
    end
  end

  // Quotient estimate from the segment reciprocal; it is low by at most one.
  always_comb begin
    qprod = QP_W'(num_f_q) * QP_W'(f_q.rcp);
    qe_d  = adtti_pkg::DT_W'(qprod >> adtti_pkg::RCP_SHIFT);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[adtti_pkg::ST_QEST]) begin
      g_q     <= f_q;
      num_g_q <= num_f_q;
      qe_g_q  <= qe_d;
    end
  end

  // Multiply back to find the remainder.
  assign qd_d = adtti_pkg::NUM_W'(qe_g_q) * adtti_pkg::NUM_W'(g_q.span_uv);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[adtti_pkg::ST_QCHK]) begin
      h_q     <= g_q;
      num_h_q <= num_g_q;
      qe_h_q  <= qe_g_q;
      qd_q    <= qd_d;
    end
  end

  // Correct the quotient and pick the result by channel kind and clamp status.
  always_comb begin
    rem  = num_h_q - qd_q;
    quot = qe_h_q + adtti_pkg::DT_W'(rem >= adtti_pkg::NUM_W'(h_q.span_uv));
    if (!h_q.diode) begin
      temp_d = h_q.lin;
    end else begin
      case (h_q.status)
        adtti_pkg::CLAMP_TOP:    temp_d = $signed(adtti_pkg::TEMP_W'(adtti_pkg::TAB_MK[0]));
        adtti_pkg::CLAMP_BOTTOM: temp_d = $signed(adtti_pkg::TEMP_W'(adtti_pkg::TAB_MK[N-1]));
        default: begin
          temp_d = $signed(adtti_pkg::TEMP_W'(h_q.tprev) - adtti_pkg::TEMP_W'(quot));
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[adtti_pkg::ST_OUT]) begin
      temp_q   <= temp_d;
      kelvin_q <= h_q.diode;
      status_q <= h_q.status;
    end
  end

  assign temperature_milli_o = temp_q;
  assign is_kelvin_o         = kelvin_q;
  assign clamp_status_o      = status_q;

endmodule

/* sv/adtti_ctrl.sv */
// Pipeline control: valid bits for every stage and the load enables derived from them.
// Depends on adtti_pkg.
module adtti_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output adtti_pkg::pipe_ctl_t ctl_o
);

  localparam int NS = adtti_pkg::NUM_STAGES;

  logic [NS-1:0] vld_d, vld_q;
  logic [NS-1:0] load;

  // A stage loads when it is empty or its contents move on; bubbles close up.
  always_comb begin
    load[NS-1] = ~vld_q[NS-1] | out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      load[k] = ~vld_q[k] | load[k+1];
    end
    vld_d[0] = load[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NS; k++) begin
      vld_d[k] = load[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = vld_q[NS-1];
  assign ctl_o.load  = load;

endmodule

/* sv/adc_to_temperature_table_interp.sv */
// Top level of the ADC to temperature converter with diode table interpolation.
// Holds the configuration registers; uses adtti_pkg, adtti_ctrl, adtti_front,
// adtti_search and adtti_interp.
//
//   Channel   Handshake                  Payload
//   input     in_valid_i / in_ready_o    channel_i, adc_code_i
//   result    out_valid_o / out_ready_i  temperature_milli_o, is_kelvin_o, clamp_status_o
//   config    cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// One item enters per cycle unless a stalled result has filled the pipeline; a result
// leaves through the nine pipeline registers from scaling to the output, the first of
// which loads at the input transfer edge itself.
// Reset empties the pipeline and loads the offset and gain with their reset values.
// A stalled result holds only the full stages with no empty stage between them and it;
// the others still move and take new items, so nothing is dropped or sent twice.
module adc_to_temperature_table_interp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [adtti_pkg::CH_W-1:0]          channel_i,
  input  logic [adtti_pkg::ADC_W-1:0]         adc_code_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [adtti_pkg::TEMP_W-1:0] temperature_milli_o,
  output logic                                is_kelvin_o,
  output logic [1:0]                          clamp_status_o,
  input  logic                                cfg_we_i,
  input  logic [0:0]                          cfg_index_i,
  input  logic [adtti_pkg::CFG_W-1:0]         cfg_wdata_i
);

  logic [adtti_pkg::OFFSET_W-1:0] offset_d, offset_q;
  logic [adtti_pkg::GAIN_W-1:0]   gain_d, gain_q;
  adtti_pkg::pipe_ctl_t           ctl;
  adtti_pkg::front_t              front;
  adtti_pkg::seg_t                seg;

  // Configuration writes.
  always_comb begin
    offset_d = offset_q;
    gain_d   = gain_q;
    if (cfg_we_i) begin
      case (adtti_pkg::cfg_idx_e'(cfg_index_i))
        adtti_pkg::CFG_OFFSET: offset_d = cfg_wdata_i[adtti_pkg::OFFSET_W-1:0];
        adtti_pkg::CFG_GAIN:   gain_d   = cfg_wdata_i[adtti_pkg::GAIN_W-1:0];
        default: begin
          offset_d = offset_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= adtti_pkg::OFFSET_W'(516980);
      gain_q   <= adtti_pkg::GAIN_W'(16466);
    end else begin
      offset_q <= offset_d;
      gain_q   <= gain_d;
    end
  end

  // Valid bits and stage enables.
  adtti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  // Scaling to microvolts and diode voltage.
  adtti_front u_front (
    .clk_i          (clk_i),
    .ctl_i          (ctl),
    .channel_i      (channel_i),
    .adc_code_i     (adc_code_i),
    .diode_offset_i (offset_q),
    .diode_gain_i   (gain_q),
    .front_o        (front)
  );

  // Segment search over the diode table.
  adtti_search u_search (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .front_i (front),
    .seg_o   (seg)
  );

  // Interpolation and output register.
  adtti_interp u_interp (
    .clk_i               (clk_i),
    .ctl_i               (ctl),
    .seg_i               (seg),
    .temperature_milli_o (temperature_milli_o),
    .is_kelvin_o         (is_kelvin_o),
    .clamp_status_o      (clamp_status_o)
  );

endmodule
